### hw/rtl/tlt_pkg.sv
// Shared types and constants for the task list table.
package tlt_pkg;

    localparam int TABLE_DEPTH_DEF = 16;
    localparam int FUNC_W          = 2;
    localparam int ID_W            = 16;
    localparam int PRI_W           = 8;
    localparam int ST_W            = 2;
    localparam int POS_W           = 5;

    typedef enum logic [FUNC_W-1:0] {
        OP_ADD    = 2'd0,
        OP_DELETE = 2'd1,
        OP_SEARCH = 2'd2,
        OP_SORT   = 2'd3
    } op_t;

    typedef enum logic [ST_W-1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2,
        ST_EMPTY     = 2'd3
    } status_t;

    // Read address source for the id/priority memories.
    typedef enum logic [1:0] {
        RD_I      = 2'd0,
        RD_I_NEXT = 2'd1,
        RD_J      = 2'd2
    } rd_sel_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_SCAN_RD,
        S_SCAN_CMP,
        S_SHIFT_CHK,
        S_SHIFT_WR,
        S_RANK_LD,
        S_RANK_CUR,
        S_RANK_RD,
        S_RANK_CMP,
        S_RANK_WR,
        S_EMIT_RD,
        S_EMIT,
        S_OUT
    } ctrl_state_t;

    typedef struct packed {
        logic    load_in;
        rd_sel_t rd_sel;
        logic    add_wr;
        logic    shift_wr;
        logic    cnt_dec;
        logic    i_clr;
        logic    i_inc;
        logic    j_clr;
        logic    j_inc;
        logic    cur_load;
        logic    rank_clr;
        logic    rank_inc;
        logic    work_wr;
        logic    res_load;
        status_t res_code;
        logic    res_pos;
        logic    res_sort;
    } tlt_cmd_t;

    typedef struct packed {
        op_t  op;
        logic full;
        logic empty;
        logic id_match;
        logic i_last;
        logic j_last;
        logic shift_more;
        logic rank_hit;
        logic out_last;
    } tlt_stat_t;

endpackage

### hw/rtl/tlt_ctrl.sv
// Operation sequencer for the task list table.
module tlt_ctrl
    import tlt_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    output logic      m_valid,
    input  logic      m_ready,
    input  tlt_stat_t stat,
    output tlt_cmd_t  cmd
);

    ctrl_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        m_valid    = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load_in = 1'b1;
                    state_next  = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                cmd.i_clr = 1'b1;
                case (stat.op)
                    OP_ADD: begin
                        cmd.res_load = 1'b1;
                        if (stat.full) begin
                            cmd.res_code = ST_FULL;
                        end else begin
                            cmd.add_wr   = 1'b1;
                            cmd.res_code = ST_OK;
                        end
                        state_next = S_OUT;
                    end
                    OP_SORT: begin
                        if (stat.empty) begin
                            cmd.res_load = 1'b1;
                            cmd.res_code = ST_EMPTY;
                            state_next   = S_OUT;
                        end else begin
                            state_next = S_RANK_LD;
                        end
                    end
                    default: begin
                        if (stat.empty) begin
                            cmd.res_load = 1'b1;
                            cmd.res_code = ST_EMPTY;
                            state_next   = S_OUT;
                        end else begin
                            state_next = S_SCAN_RD;
                        end
                    end
                endcase
            end
            S_SCAN_RD: begin
                cmd.rd_sel = RD_I;
                state_next = S_SCAN_CMP;
            end
            S_SCAN_CMP: begin
                if (stat.id_match) begin
                    if (stat.op == OP_SEARCH) begin
                        cmd.res_load = 1'b1;
                        cmd.res_code = ST_OK;
                        cmd.res_pos  = 1'b1;
                        state_next   = S_OUT;
                    end else begin
                        state_next = S_SHIFT_CHK;
                    end
                end else if (stat.i_last) begin
                    cmd.res_load = 1'b1;
                    cmd.res_code = ST_NOT_FOUND;
                    state_next   = S_OUT;
                end else begin
                    cmd.i_inc  = 1'b1;
                    state_next = S_SCAN_RD;
                end
            end
            S_SHIFT_CHK: begin
                if (stat.shift_more) begin
                    cmd.rd_sel = RD_I_NEXT;
                    state_next = S_SHIFT_WR;
                end else begin
                    cmd.cnt_dec  = 1'b1;
                    cmd.res_load = 1'b1;
                    cmd.res_code = ST_OK;
                    state_next   = S_OUT;
                end
            end
            S_SHIFT_WR: begin
                // move entry i+1 down into slot i
                cmd.shift_wr = 1'b1;
                cmd.i_inc    = 1'b1;
                state_next   = S_SHIFT_CHK;
            end
            S_RANK_LD: begin
                cmd.rd_sel = RD_I;
                state_next = S_RANK_CUR;
            end
            S_RANK_CUR: begin
                cmd.cur_load = 1'b1;
                cmd.j_clr    = 1'b1;
                cmd.rank_clr = 1'b1;
                state_next   = S_RANK_RD;
            end
            S_RANK_RD: begin
                cmd.rd_sel = RD_J;
                state_next = S_RANK_CMP;
            end
            S_RANK_CMP: begin
                cmd.rank_inc = stat.rank_hit;
                if (stat.j_last) begin
                    state_next = S_RANK_WR;
                end else begin
                    cmd.j_inc  = 1'b1;
                    state_next = S_RANK_RD;
                end
            end
            S_RANK_WR: begin
                cmd.work_wr = 1'b1;
                if (stat.i_last) begin
                    cmd.i_clr  = 1'b1;
                    state_next = S_EMIT_RD;
                end else begin
                    cmd.i_inc  = 1'b1;
                    state_next = S_RANK_LD;
                end
            end
            S_EMIT_RD: begin
                state_next = S_EMIT;
            end
            S_EMIT: begin
                cmd.res_load = 1'b1;
                cmd.res_code = ST_OK;
                cmd.res_sort = 1'b1;
                state_next   = S_OUT;
            end
            S_OUT: begin
                m_valid = 1'b1;
                if (m_ready) begin
                    if (stat.out_last) begin
                        state_next = S_IDLE;
                    end else begin
                        cmd.i_inc  = 1'b1;
                        state_next = S_EMIT_RD;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

### hw/rtl/tlt_dp.sv
// Table memories, index counters, compare logic and result register.
module tlt_dp
    import tlt_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  tlt_cmd_t          cmd,
    output tlt_stat_t         stat,
    input  logic [FUNC_W-1:0] s_func,
    input  logic [ID_W-1:0]   s_task_id,
    input  logic [PRI_W-1:0]  s_priority_req,
    output logic [ST_W-1:0]   m_status,
    output logic [POS_W-1:0]  m_position,
    output logic [PRI_W-1:0]  m_sorted_priority,
    output logic              m_last
);

    localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int SW = (CW + 1 > POS_W) ? CW + 1 : POS_W;

    logic [ID_W-1:0]  id_mem   [TABLE_DEPTH];
    logic [PRI_W-1:0] pri_mem  [TABLE_DEPTH];
    logic [PRI_W-1:0] work_mem [TABLE_DEPTH];

    logic [ID_W-1:0]  id_q_reg;
    logic [PRI_W-1:0] pri_q_reg;
    logic [PRI_W-1:0] work_q_reg;

    op_t              op_reg;
    logic [ID_W-1:0]  key_reg;
    logic [PRI_W-1:0] pri_in_reg;
    logic [CW-1:0]    count_reg;
    logic [IW-1:0]    i_reg;
    logic [IW-1:0]    j_reg;
    logic [IW-1:0]    rank_reg;
    logic [PRI_W-1:0] cur_reg;

    status_t          st_reg;
    logic [POS_W-1:0] pos_reg;
    logic [PRI_W-1:0] srt_reg;
    logic             last_reg;

    logic [IW-1:0]    rd_addr;
    logic [IW-1:0]    wr_addr;
    logic [ID_W-1:0]  wr_id;
    logic [PRI_W-1:0] wr_pri;
    logic             wr_en;
    logic [CW-1:0]    i_plus;
    logic [CW-1:0]    j_plus;
    logic [SW-1:0]    pos_sum;

    assign i_plus  = CW'(i_reg) + CW'(1);
    assign j_plus  = CW'(j_reg) + CW'(1);
    assign pos_sum = SW'(i_reg) + SW'(1);

    always_comb begin
        case (cmd.rd_sel)
            RD_I_NEXT: rd_addr = i_plus[IW-1:0];
            RD_J:      rd_addr = j_reg;
            default:   rd_addr = i_reg;
        endcase
    end

    assign wr_en   = cmd.add_wr | cmd.shift_wr;
    assign wr_addr = cmd.add_wr ? count_reg[IW-1:0] : i_reg;
    assign wr_id   = cmd.add_wr ? key_reg : id_q_reg;
    assign wr_pri  = cmd.add_wr ? pri_in_reg : pri_q_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            id_mem[wr_addr]  <= wr_id;
            pri_mem[wr_addr] <= wr_pri;
        end
        id_q_reg  <= id_mem[rd_addr];
        pri_q_reg <= pri_mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (cmd.work_wr) begin
            work_mem[rank_reg] <= cur_reg;
        end
        work_q_reg <= work_mem[i_reg];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            i_reg     <= '0;
            j_reg     <= '0;
            rank_reg  <= '0;
        end else begin
            if (cmd.add_wr) begin
                count_reg <= count_reg + CW'(1);
            end else if (cmd.cnt_dec) begin
                count_reg <= count_reg - CW'(1);
            end
            if (cmd.i_clr) begin
                i_reg <= '0;
            end else if (cmd.i_inc) begin
                i_reg <= i_reg + IW'(1);
            end
            if (cmd.j_clr) begin
                j_reg <= '0;
            end else if (cmd.j_inc) begin
                j_reg <= j_reg + IW'(1);
            end
            if (cmd.rank_clr) begin
                rank_reg <= '0;
            end else if (cmd.rank_inc) begin
                rank_reg <= rank_reg + IW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            op_reg     <= op_t'(s_func);
            key_reg    <= s_task_id;
            pri_in_reg <= s_priority_req;
        end
        if (cmd.cur_load) begin
            cur_reg <= pri_q_reg;
        end
        if (cmd.res_load) begin
            st_reg   <= cmd.res_code;
            pos_reg  <= cmd.res_pos ? pos_sum[POS_W-1:0] : '0;
            srt_reg  <= cmd.res_sort ? work_q_reg : '0;
            last_reg <= cmd.res_sort ? (i_plus == count_reg) : 1'b1;
        end
    end

    always_comb begin
        stat.op         = op_reg;
        stat.full       = (count_reg == CW'(TABLE_DEPTH));
        stat.empty      = (count_reg == '0);
        stat.id_match   = (id_q_reg == key_reg);
        stat.i_last     = (i_plus == count_reg);
        stat.j_last     = (j_plus == count_reg);
        stat.shift_more = (i_plus < count_reg);
        // stable rank: smaller values, and equal values stored earlier
        stat.rank_hit   = (pri_q_reg < cur_reg) || ((pri_q_reg == cur_reg) && (j_reg < i_reg));
        stat.out_last   = last_reg;
    end

    assign m_status          = st_reg;
    assign m_position        = pos_reg;
    assign m_sorted_priority = srt_reg;
    assign m_last            = last_reg;

endmodule

### hw/rtl/task_list_table.sv
// Task list table: an insertion-ordered table of up to TABLE_DEPTH tasks (16-bit id, 8-bit
// priority) that takes one operation per transaction and handles one at a time. Add writes
// the tail; search and delete scan ids entry by entry, and delete then shifts the remaining
// entries down by one slot. Sort ranks each priority against all others through the
// single read port of the priority memory into a scratch memory, then returns one
// transaction per entry, ascending, with m_last on the final one; an empty table gives one
// result with status empty. The next operation is taken once the last result of the
// current one has been accepted.
module task_list_table
    import tlt_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [FUNC_W-1:0] s_func,
    input  logic [ID_W-1:0]   s_task_id,
    input  logic [PRI_W-1:0]  s_priority_req,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [ST_W-1:0]   m_status,
    output logic [POS_W-1:0]  m_position,
    output logic [PRI_W-1:0]  m_sorted_priority,
    output logic              m_last
);

    tlt_cmd_t  cmd;
    tlt_stat_t stat;

    tlt_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    tlt_dp #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dp (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cmd               (cmd),
        .stat              (stat),
        .s_func            (s_func),
        .s_task_id         (s_task_id),
        .s_priority_req    (s_priority_req),
        .m_status          (m_status),
        .m_position        (m_position),
        .m_sorted_priority (m_sorted_priority),
        .m_last            (m_last)
    );

endmodule
